### rtl/core/pedal_footswitch_gesture_controller_assert.svh
// Assertion macros shared by the footswitch gesture controller modules.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef PEDAL_FOOTSWITCH_GESTURE_CONTROLLER_ASSERT_SVH
`define PEDAL_FOOTSWITCH_GESTURE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PFGC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pfgc same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PFGC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pfgc next-cycle check failed");

`endif

### rtl/core/pfgc_pkg.sv
// Types and constants of the footswitch gesture controller.
// Used by the interfaces, the gesture core, the blink unit and the top level.
package pfgc_pkg;

	localparam int unsigned CountWidth = 10;
	localparam int unsigned IndexWidth = 2;

	localparam logic [CountWidth-1:0] CountMax = 10'd1023;
	localparam logic [5:0] BlinkLong = 6'd40;
	localparam logic [4:0] BlinkShort = 5'd25;

	// Register indexes of the configuration port.
	localparam logic [IndexWidth-1:0] RegHoldTicks = 2'd0;
	localparam logic [IndexWidth-1:0] RegButtonHoldTicks = 2'd1;
	localparam logic [IndexWidth-1:0] RegButtonFitted = 2'd2;

	localparam logic [CountWidth-1:0] HoldTicksReset = 10'd94;
	localparam logic [CountWidth-1:0] ButtonHoldTicksReset = 10'd33;

	// LFO page codes.
	localparam logic [1:0] PageNone = 2'd0;
	localparam logic [1:0] PageOne = 2'd1;
	localparam logic [1:0] PageTwo = 2'd2;

	typedef struct packed {
		logic footswitch_one;
		logic footswitch_two;
		logic toggle_four;
		logic lfo_button;
		logic engine_recording;
	} pfgc_in_t;

	typedef struct packed {
		logic       bypass_out;
		logic       record_request;
		logic       page_three;
		logic [1:0] page_shown;
		logic       division_latch;
		logic       clear_pulse;
		logic       reset_pulse;
		logic       engaged_led;
		logic       led_two_red;
		logic       led_two_green;
		logic       button_led_red;
		logic       button_led_green;
	} pfgc_out_t;

	// From the gesture core to the blink unit, all taken after this item's update.
	typedef struct packed {
		logic       clear_load;
		logic       reset_load;
		logic       latch_load;
		logic       record_latch;
		logic       bypass_latch;
		logic       division_state;
		logic [1:0] page_shown;
	} pfgc_blink_ctl_t;

	typedef struct packed {
		logic record_request;
		logic page_three;
		logic clear_pulse;
		logic reset_pulse;
	} pfgc_flags_t;

	typedef struct packed {
		logic red;
		logic green;
		logic button_red;
		logic button_green;
	} pfgc_led_t;

endpackage

### rtl/core/pfgc_if.sv
// Valid/ready channel interfaces of the footswitch gesture controller.
// Depends on pfgc_pkg for the payload types.
interface pfgc_in_if;
	logic valid;
	logic ready;
	pfgc_pkg::pfgc_in_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface pfgc_out_if;
	logic valid;
	logic ready;
	pfgc_pkg::pfgc_out_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/pfgc_core.sv
// Gesture state of the footswitch controller: button, footswitches, record,
// bypass and the page-three division latch. Depends on pfgc_pkg.
`include "pedal_footswitch_gesture_controller_assert.svh"

module pfgc_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  pfgc_pkg::pfgc_in_t                   item,
	input  logic [pfgc_pkg::CountWidth-1:0]      hold_ticks,
	input  logic [pfgc_pkg::CountWidth-1:0]      button_hold_ticks,
	input  logic                                 button_fitted,
	output pfgc_pkg::pfgc_blink_ctl_t            ctl,
	output pfgc_pkg::pfgc_flags_t                flags
);

	function automatic logic [pfgc_pkg::CountWidth-1:0] sat_inc(
		input logic [pfgc_pkg::CountWidth-1:0] c);
		return (c == pfgc_pkg::CountMax) ? c : c + 1'b1;
	endfunction

	function automatic logic [1:0] next_page(input logic [1:0] p);
		logic [1:0] n;
		case (p)
			pfgc_pkg::PageNone: n = pfgc_pkg::PageOne;
			pfgc_pkg::PageOne:  n = pfgc_pkg::PageTwo;
			pfgc_pkg::PageTwo:  n = pfgc_pkg::PageNone;
			default:            n = pfgc_pkg::PageOne;
		endcase
		return n;
	endfunction

	logic bypass_q, record_q, both_used_q;
	logic fs1_down_q, fs1_used_q, fs2_down_q, fs2_used_q;
	logic [pfgc_pkg::CountWidth-1:0] fs1_cnt_q, fs2_cnt_q, btn_cnt_q;
	logic btn_down_q, btn_held_q;
	logic [1:0] page_q, last_page_q;
	logic division_q, toggle_ref_q, p3_before_q;

	logic bypass_d, record_d, both_used_d;
	logic fs1_down_d, fs1_used_d, fs2_down_d, fs2_used_d;
	logic [pfgc_pkg::CountWidth-1:0] fs1_cnt_d, fs2_cnt_d, btn_cnt_d;
	logic btn_down_d, btn_held_d;
	logic [1:0] page_d, last_page_d;
	logic division_d, toggle_ref_d, p3_before_d;

	logic p1, p2, page3, btn;
	logic clear_p, reset_p, latch_load, rec_req;
	logic [1:0] page_shown;

	assign p1 = item.footswitch_one;
	assign p2 = item.footswitch_two;
	assign page3 = p1 & ~p2;
	assign btn = button_fitted & item.lfo_button;

	// The sections run in a fixed order on the updated values, so each one
	// sees what the one before it has just written.
	always_comb begin
		bypass_d = bypass_q;
		record_d = record_q;
		both_used_d = both_used_q;
		fs1_down_d = fs1_down_q;
		fs1_used_d = fs1_used_q;
		fs1_cnt_d = fs1_cnt_q;
		fs2_down_d = fs2_down_q;
		fs2_used_d = fs2_used_q;
		fs2_cnt_d = fs2_cnt_q;
		btn_down_d = btn_down_q;
		btn_held_d = btn_held_q;
		btn_cnt_d = btn_cnt_q;
		page_d = page_q;
		last_page_d = last_page_q;
		division_d = division_q;
		toggle_ref_d = toggle_ref_q;
		clear_p = 1'b0;
		reset_p = 1'b0;
		latch_load = 1'b0;

		if (btn) begin
			if (!btn_down_d) begin
				btn_down_d = 1'b1;
				btn_cnt_d = '0;
				btn_held_d = 1'b0;
			end
			btn_cnt_d = sat_inc(btn_cnt_d);
			if (!btn_held_d && btn_cnt_d >= button_hold_ticks) begin
				btn_held_d = 1'b1;
			end
		end else if (btn_down_d) begin
			btn_down_d = 1'b0;
			if (!btn_held_d) begin
				page_d = next_page(page_d);
				if (page_d != pfgc_pkg::PageNone) begin
					last_page_d = page_d;
				end
			end
		end
		page_shown = btn_held_d ? last_page_d : page_d;

		if (p1 && p2) begin
			fs1_cnt_d = sat_inc(fs1_cnt_d);
			if (!both_used_d && fs1_cnt_d >= hold_ticks) begin
				reset_p = 1'b1;
				both_used_d = 1'b1;
			end
			fs1_down_d = 1'b0;
			fs1_used_d = 1'b1;
			fs2_down_d = 1'b0;
			fs2_used_d = 1'b1;
		end else if (both_used_d) begin
			if (!p1 && !p2) begin
				both_used_d = 1'b0;
				fs1_cnt_d = '0;
			end
		end

		if (page3) begin
			fs1_down_d = 1'b0;
			fs1_used_d = 1'b0;
			fs1_cnt_d = '0;
		end else if (p1) begin
			if (!fs1_down_d) begin
				fs1_down_d = 1'b1;
				fs1_cnt_d = '0;
				fs1_used_d = 1'b0;
			end
			fs1_cnt_d = sat_inc(fs1_cnt_d);
			if (!fs1_used_d && fs1_cnt_d >= hold_ticks) begin
				fs1_used_d = 1'b1;
			end
		end else if (fs1_down_d) begin
			fs1_down_d = 1'b0;
			if (!fs1_used_d) begin
				bypass_d = ~bypass_d;
			end
		end

		if (p2) begin
			if (!fs2_down_d) begin
				fs2_down_d = 1'b1;
				fs2_cnt_d = '0;
				fs2_used_d = 1'b0;
			end
			fs2_cnt_d = sat_inc(fs2_cnt_d);
			if (!fs2_used_d && fs2_cnt_d >= hold_ticks) begin
				clear_p = 1'b1;
				record_d = 1'b0;
				fs2_used_d = 1'b1;
			end
		end else if (fs2_down_d) begin
			fs2_down_d = 1'b0;
			if (!fs2_used_d) begin
				record_d = ~record_d;
			end
		end

		if (page3) begin
			if (!p3_before_q) begin
				toggle_ref_d = item.toggle_four;
			end else if (item.toggle_four != toggle_ref_d) begin
				division_d = ~division_d;
				toggle_ref_d = item.toggle_four;
				latch_load = 1'b1;
			end
		end
		p3_before_d = page3;

		// The engine sees the latch before an automatic stop clears it.
		rec_req = record_d;
		if (record_d && !item.engine_recording) begin
			record_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bypass_q <= 1'b1;
			record_q <= 1'b0;
			both_used_q <= 1'b0;
			fs1_down_q <= 1'b0;
			fs1_used_q <= 1'b0;
			fs1_cnt_q <= '0;
			fs2_down_q <= 1'b0;
			fs2_used_q <= 1'b0;
			fs2_cnt_q <= '0;
			btn_down_q <= 1'b0;
			btn_held_q <= 1'b0;
			btn_cnt_q <= '0;
			page_q <= pfgc_pkg::PageNone;
			last_page_q <= pfgc_pkg::PageOne;
			division_q <= 1'b0;
			toggle_ref_q <= 1'b0;
			p3_before_q <= 1'b0;
		end else if (en) begin
			bypass_q <= bypass_d;
			record_q <= record_d;
			both_used_q <= both_used_d;
			fs1_down_q <= fs1_down_d;
			fs1_used_q <= fs1_used_d;
			fs1_cnt_q <= fs1_cnt_d;
			fs2_down_q <= fs2_down_d;
			fs2_used_q <= fs2_used_d;
			fs2_cnt_q <= fs2_cnt_d;
			btn_down_q <= btn_down_d;
			btn_held_q <= btn_held_d;
			btn_cnt_q <= btn_cnt_d;
			page_q <= page_d;
			last_page_q <= last_page_d;
			division_q <= division_d;
			toggle_ref_q <= toggle_ref_d;
			p3_before_q <= p3_before_d;
		end
	end

	assign ctl.clear_load = clear_p;
	assign ctl.reset_load = reset_p;
	assign ctl.latch_load = latch_load;
	assign ctl.record_latch = record_d;
	assign ctl.bypass_latch = bypass_d;
	assign ctl.division_state = division_d;
	assign ctl.page_shown = page_shown;

	assign flags.record_request = rec_req;
	assign flags.page_three = page3;
	assign flags.clear_pulse = clear_p;
	assign flags.reset_pulse = reset_p;

	`PFGC_ASSERT_IMPL(a_page_in_range, 1'b1, page_q != 2'd3)
	`PFGC_ASSERT_IMPL(a_last_page_set, 1'b1, last_page_q != pfgc_pkg::PageNone)
	`PFGC_ASSERT_NEXT(a_reset_marks_used, en && reset_p, both_used_q)

endmodule

### rtl/core/pfgc_blink.sv
// LED blink chain and LED legs of the footswitch gesture controller.
// Depends on pfgc_pkg; fed by pfgc_core once per item.
`include "pedal_footswitch_gesture_controller_assert.svh"

module pfgc_blink (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       button_fitted,
	input  pfgc_pkg::pfgc_blink_ctl_t  ctl,
	output pfgc_pkg::pfgc_led_t        led
);

	// Parity of the count divided by six, nine and five, as small tables.
	function automatic logic odd_sixth(input logic [5:0] v);
		logic r;
		case (v) inside
			[6'd6:6'd11], [6'd18:6'd23], [6'd30:6'd35], [6'd42:6'd47], [6'd54:6'd59]:
				r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic odd_ninth(input logic [5:0] v);
		logic r;
		case (v) inside
			[6'd9:6'd17], [6'd27:6'd35], [6'd45:6'd53]: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic odd_fifth(input logic [5:0] v);
		logic r;
		case (v) inside
			[6'd5:6'd9], [6'd15:6'd19], [6'd25:6'd29], [6'd35:6'd39], [6'd45:6'd49],
			[6'd55:6'd59]:
				r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	logic [5:0] clear_q, reset_q;
	logic [4:0] latch_q;
	logic [5:0] clear_d, reset_d;
	logic [4:0] latch_d;
	logic red, green, blinking, btn_red, btn_green;

	always_comb begin
		clear_d = ctl.clear_load ? pfgc_pkg::BlinkLong : clear_q;
		reset_d = ctl.reset_load ? pfgc_pkg::BlinkLong : reset_q;
		latch_d = ctl.latch_load ? pfgc_pkg::BlinkShort : latch_q;

		// Only the first running counter of the chain drives red and counts down.
		if (clear_d != 6'd0) begin
			red = odd_sixth(clear_d);
			clear_d = clear_d - 6'd1;
		end else if (reset_d != 6'd0) begin
			red = odd_ninth(reset_d);
			reset_d = reset_d - 6'd1;
		end else if (latch_d != 5'd0) begin
			red = latch_d[2];
			latch_d = latch_d - 5'd1;
		end else begin
			red = ctl.record_latch;
		end

		blinking = (clear_d != 6'd0) || (reset_d != 6'd0) || (latch_d != 5'd0);
		green = 1'b0;
		btn_red = 1'b0;
		btn_green = 1'b0;
		if (button_fitted) begin
			green = blinking ? red : (~ctl.record_latch & ~ctl.bypass_latch);
			if (ctl.division_state && !ctl.record_latch && !blinking) begin
				green = 1'b1;
			end
			if (reset_d != 6'd0) begin
				btn_red = odd_fifth(reset_d);
				btn_green = btn_red;
			end else begin
				btn_red = ctl.page_shown == pfgc_pkg::PageOne;
				btn_green = ctl.page_shown == pfgc_pkg::PageTwo;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q <= '0;
			reset_q <= '0;
			latch_q <= '0;
		end else if (en) begin
			clear_q <= clear_d;
			reset_q <= reset_d;
			latch_q <= latch_d;
		end
	end

	assign led.red = red;
	assign led.green = green;
	assign led.button_red = btn_red;
	assign led.button_green = btn_green;

	`PFGC_ASSERT_NEXT(a_clear_starts, en && ctl.clear_load, clear_q == pfgc_pkg::BlinkLong - 6'd1)
	`PFGC_ASSERT_IMPL(a_latch_bound, 1'b1, latch_q <= pfgc_pkg::BlinkShort)
	`PFGC_ASSERT_IMPL(a_unfitted_dark, !button_fitted, !green && !btn_red && !btn_green)

endmodule

### rtl/core/pedal_footswitch_gesture_controller.sv
// Footswitch gesture controller for a looper pedal.
// One item on "items" is one audio-block tick: the debounced footswitch, SW4
// and LFO button levels plus the engine's record status. Each item yields one
// result on "results": bypass, record request, page three, LFO page, the
// division latch, one-tick clear and reset commands and the LED legs.
// An accepted item sits in the input register, then the gesture logic writes the
// result register, from which the result is offered on "results".
// Throughput: one item per cycle; input register and result register form a
// two-entry pipe, so an item is taken while an earlier result waits.
// When the receiver stalls the result holds, the input register fills, and
// then ready drops until the result is taken.
// Configuration: cfg_write with cfg_index 0 (hold ticks), 1 (button hold
// ticks) or 2 (button fitted) stores cfg_data at that edge; other indexes are
// ignored. Write only while the block holds no item.
// Reset (arst_n low) empties the pipe, restores the register defaults (94, 33,
// not fitted) and leaves the effect bypassed with all counters cleared.
`include "pedal_footswitch_gesture_controller_assert.svh"

module pedal_footswitch_gesture_controller (
	input  logic                                 clk,
	input  logic                                 arst_n,
	pfgc_in_if.sink                              items,
	pfgc_out_if.source                           results,
	input  logic                                 cfg_write,
	input  logic [pfgc_pkg::IndexWidth-1:0]      cfg_index,
	input  logic [pfgc_pkg::CountWidth-1:0]      cfg_data
);

	logic [pfgc_pkg::CountWidth-1:0] hold_ticks_q, button_hold_ticks_q;
	logic button_fitted_q;

	logic valid_s1;
	pfgc_pkg::pfgc_in_t item_s1;
	logic out_valid_q;
	pfgc_pkg::pfgc_out_t result_q;

	logic advance, take;
	pfgc_pkg::pfgc_blink_ctl_t ctl;
	pfgc_pkg::pfgc_flags_t flags;
	pfgc_pkg::pfgc_led_t led;
	pfgc_pkg::pfgc_out_t result_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q <= pfgc_pkg::HoldTicksReset;
			button_hold_ticks_q <= pfgc_pkg::ButtonHoldTicksReset;
			button_fitted_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				pfgc_pkg::RegHoldTicks:       hold_ticks_q <= cfg_data;
				pfgc_pkg::RegButtonHoldTicks: button_hold_ticks_q <= cfg_data;
				pfgc_pkg::RegButtonFitted:    button_fitted_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign advance = valid_s1 & (~out_valid_q | results.ready);
	assign items.ready = ~valid_s1 | advance;
	assign take = items.valid & items.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= items.payload;
		end
	end

	pfgc_core u_core (
		.clk               (clk),
		.arst_n            (arst_n),
		.en                (advance),
		.item              (item_s1),
		.hold_ticks        (hold_ticks_q),
		.button_hold_ticks (button_hold_ticks_q),
		.button_fitted     (button_fitted_q),
		.ctl               (ctl),
		.flags             (flags)
	);

	pfgc_blink u_blink (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (advance),
		.button_fitted (button_fitted_q),
		.ctl           (ctl),
		.led           (led)
	);

	always_comb begin
		result_d.bypass_out = ctl.bypass_latch;
		result_d.record_request = flags.record_request;
		result_d.page_three = flags.page_three;
		result_d.page_shown = ctl.page_shown;
		result_d.division_latch = ctl.division_state;
		result_d.clear_pulse = flags.clear_pulse;
		result_d.reset_pulse = flags.reset_pulse;
		result_d.engaged_led = ~ctl.bypass_latch;
		result_d.led_two_red = led.red;
		result_d.led_two_green = led.green;
		result_d.button_led_red = led.button_red;
		result_d.button_led_green = led.button_green;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign results.valid = out_valid_q;
	assign results.payload = result_q;

	`PFGC_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_q)
	`PFGC_ASSERT_NEXT(a_stall_keeps_item, valid_s1 && !advance, valid_s1)
	`PFGC_ASSERT_IMPL(a_ready_when_empty, !valid_s1, items.ready)

endmodule
